@@ rtl/skt_pkg.sv @@
// ---------------------------------------------------------------------------
// Sorted key table package
// Widths, operation codes and shared types of the sorted key table.
// ---------------------------------------------------------------------------
`default_nettype none

package skt_pkg;

  // Table geometry
  localparam int CAPACITY = 64;
  localparam int AW       = $clog2(CAPACITY);
  localparam int CW       = $clog2(CAPACITY + 1);

  // Field widths
  localparam int KEY_W = 31;
  localparam int IDX_W = 6;
  localparam int OP_W  = 2;

  // Operation codes
  localparam logic [OP_W-1:0] OP_FIND_INS = 2'd0;
  localparam logic [OP_W-1:0] OP_FIND     = 2'd1;
  localparam logic [OP_W-1:0] OP_NEXT     = 2'd2;

  typedef logic [KEY_W-1:0] key_t;
  typedef logic [CW-1:0]    count_t;
  typedef logic [AW-1:0]    addr_t;

  // Control from the sequencer to the search unit
  typedef struct packed {
    logic init;    // load bounds for a new search
    logic step;    // apply one compare result
    logic strict;  // move right on equal as well
  } srch_ctrl_t;

  // Low result-index bits of a table position
  function automatic logic [IDX_W-1:0] to_idx(input count_t p);
    logic [CW+IDX_W-1:0] w;
    w = {{IDX_W{1'b0}}, p};
    return w[IDX_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ rtl/sorted_key_table_find_or_insert_core.sv @@
// ---------------------------------------------------------------------------
// Sorted key table find-or-insert core
// Ascending table of distinct keys with binary search and ordered insert.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall, in_op, in_key) carries one request.
//   Op find-or-insert returns the key's index, inserting it in order when
//   absent and not full; find-only returns index and found; next-greater
//   returns the smallest stored key above in_key, or the end key when none.
//   Result channel (out_valid / out_stall) carries one transaction per
//   request. cfg_valid / cfg_ready write the end-key register; cfg_ready
//   is always high.
//   Flow: one request at a time. A search does a memory read and a
//   compare per step, then a final bound check; resolve follows, and
//   hand-over loads the result into the output register. An insert,
//   between resolve and hand-over, moves each entry above the insert
//   position up (read then write on the store) and then writes the
//   new key.
//   Reset empties the table and clears end key. A stalled result is held
//   in the output register; the next request is accepted meanwhile but
//   its result waits until the previous one is taken.
// ---------------------------------------------------------------------------
`default_nettype none

module sorted_key_table_find_or_insert_core (
  input  logic                         clk,
  input  logic                         rst_n,
  // Configuration
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [skt_pkg::KEY_W-1:0]    cfg_end_key,
  // Requests
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [skt_pkg::OP_W-1:0]     in_op,
  input  logic [skt_pkg::KEY_W-1:0]    in_key,
  // Results
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [skt_pkg::IDX_W-1:0]    out_index,
  output logic                         out_found,
  output logic                         out_inserted,
  output logic                         out_full_res,
  output logic [skt_pkg::KEY_W-1:0]    out_next_key
);
  import skt_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SEARCH  = 3'd1;
  localparam logic [2:0] S_CMP     = 3'd2;
  localparam logic [2:0] S_RESOLVE = 3'd3;
  localparam logic [2:0] S_SH_RD   = 3'd4;
  localparam logic [2:0] S_SH_WR   = 3'd5;
  localparam logic [2:0] S_INS     = 3'd6;
  localparam logic [2:0] S_DONE    = 3'd7;

  logic [2:0]      state_r, state_nxt;
  logic [OP_W-1:0] op_r;
  key_t            key_r;
  key_t            end_key_r;
  count_t          count_r;
  count_t          j_r, j_nxt;
  count_t          jm1;

  // Pending result
  logic [IDX_W-1:0] res_idx_r, res_idx_nxt;
  logic             res_found_r, res_found_nxt;
  logic             res_ins_r, res_ins_nxt;
  logic             res_full_r, res_full_nxt;
  key_t             res_next_r, res_next_nxt;

  // Output register
  logic             out_valid_r;
  logic [IDX_W-1:0] out_idx_r;
  logic             out_found_r, out_ins_r, out_full_r;
  key_t             out_next_r;

  // Key store
  key_t   mem [CAPACITY];
  key_t   rd_data_r;
  addr_t  rd_addr;
  addr_t  wr_addr;
  key_t   wr_data;
  logic   wr_en;

  // Search unit
  srch_ctrl_t sctrl;
  count_t     mid, pos;
  key_t       hit_key;
  logic       busy, hit_ok, hit_eq;

  logic accept, out_free, load_out;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign load_out = (state_r == S_DONE) && out_free;
  assign jm1      = j_r - CW'(1);

  skt_search u_search (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (sctrl),
    .key     (key_r),
    .count   (count_r),
    .rd_data (rd_data_r),
    .mid     (mid),
    .busy    (busy),
    .pos     (pos),
    .hit_key (hit_key),
    .hit_ok  (hit_ok),
    .hit_eq  (hit_eq)
  );

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    j_nxt         = j_r;
    res_idx_nxt   = res_idx_r;
    res_found_nxt = res_found_r;
    res_ins_nxt   = res_ins_r;
    res_full_nxt  = res_full_r;
    res_next_nxt  = res_next_r;
    sctrl.init    = 1'b0;
    sctrl.step    = 1'b0;
    sctrl.strict  = (op_r == OP_NEXT);
    rd_addr       = mid[AW-1:0];
    wr_en         = 1'b0;
    wr_addr       = j_r[AW-1:0];
    wr_data       = rd_data_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          sctrl.init    = 1'b1;
          res_idx_nxt   = '0;
          res_found_nxt = 1'b0;
          res_ins_nxt   = 1'b0;
          res_full_nxt  = 1'b0;
          res_next_nxt  = '0;
          state_nxt     = S_SEARCH;
        end
      end
      S_SEARCH: begin
        // Issue the read of the midpoint
        rd_addr = mid[AW-1:0];
        if (busy) begin
          state_nxt = S_CMP;
        end else begin
          state_nxt = S_RESOLVE;
        end
      end
      S_CMP: begin
        sctrl.step = 1'b1;
        state_nxt  = S_SEARCH;
      end
      S_RESOLVE: begin
        state_nxt = S_DONE;
        case (op_r)
          OP_FIND_INS: begin
            if (hit_ok && hit_eq) begin
              res_idx_nxt   = to_idx(pos);
              res_found_nxt = 1'b1;
            end else if (count_r >= CW'(CAPACITY)) begin
              res_full_nxt = 1'b1;
            end else begin
              j_nxt = count_r;
              if (count_r == pos) begin
                state_nxt = S_INS;
              end else begin
                state_nxt = S_SH_RD;
              end
            end
          end
          OP_FIND: begin
            if (hit_ok && hit_eq) begin
              res_idx_nxt   = to_idx(pos);
              res_found_nxt = 1'b1;
            end
          end
          OP_NEXT: begin
            if (hit_ok) begin
              res_idx_nxt   = to_idx(pos);
              res_found_nxt = 1'b1;
              res_next_nxt  = hit_key;
            end else begin
              res_next_nxt = end_key_r;
            end
          end
          default: begin
            // unused code: all-zero result
          end
        endcase
      end
      S_SH_RD: begin
        rd_addr   = jm1[AW-1:0];
        state_nxt = S_SH_WR;
      end
      S_SH_WR: begin
        // Move one entry up
        wr_en   = 1'b1;
        wr_addr = j_r[AW-1:0];
        wr_data = rd_data_r;
        j_nxt   = jm1;
        if (jm1 == pos) begin
          state_nxt = S_INS;
        end else begin
          state_nxt = S_SH_RD;
        end
      end
      S_INS: begin
        wr_en       = 1'b1;
        wr_addr     = pos[AW-1:0];
        wr_data     = key_r;
        res_idx_nxt = to_idx(pos);
        res_ins_nxt = 1'b1;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      end_key_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_INS) begin
        count_r <= count_r + CW'(1);
      end
      if (cfg_valid) begin
        end_key_r <= cfg_end_key;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= in_op;
      key_r <= in_key;
    end
    j_r         <= j_nxt;
    res_idx_r   <= res_idx_nxt;
    res_found_r <= res_found_nxt;
    res_ins_r   <= res_ins_nxt;
    res_full_r  <= res_full_nxt;
    res_next_r  <= res_next_nxt;
    if (load_out) begin
      out_idx_r   <= res_idx_r;
      out_found_r <= res_found_r;
      out_ins_r   <= res_ins_r;
      out_full_r  <= res_full_r;
      out_next_r  <= res_next_r;
    end
  end

  // Key store: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign cfg_ready    = 1'b1;
  assign out_valid    = out_valid_r;
  assign out_index    = out_idx_r;
  assign out_found    = out_found_r;
  assign out_inserted = out_ins_r;
  assign out_full_res = out_full_r;
  assign out_next_key = out_next_r;

endmodule

`default_nettype wire

@@ rtl/skt_search.sv @@
// ---------------------------------------------------------------------------
// Sorted key table search unit
// Binary search bounds and the single shared key comparator.
// ---------------------------------------------------------------------------
`default_nettype none

module skt_search (
  input  logic                clk,
  input  logic                rst_n,
  input  skt_pkg::srch_ctrl_t ctrl,
  input  skt_pkg::key_t       key,
  input  skt_pkg::count_t     count,
  input  skt_pkg::key_t       rd_data,
  output skt_pkg::count_t     mid,
  output logic                busy,
  output skt_pkg::count_t     pos,
  output skt_pkg::key_t       hit_key,
  output logic                hit_ok,
  output logic                hit_eq
);
  import skt_pkg::*;

  count_t lo_r, hi_r;
  key_t   hv_r;
  logic   hv_ok_r, hv_eq_r;
  logic   lt, eq, go_right;

  // Midpoint of the half-open interval [lo, hi)
  assign mid  = lo_r + ((hi_r - lo_r) >> 1);
  assign busy = (lo_r < hi_r);

  // Shared comparator
  assign lt       = (rd_data < key);
  assign eq       = (rd_data == key);
  assign go_right = lt | (ctrl.strict & eq);

  // Narrow the bounds; remember the key sitting at the upper bound
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lo_r    <= '0;
      hi_r    <= '0;
      hv_ok_r <= 1'b0;
      hv_eq_r <= 1'b0;
    end else if (ctrl.init) begin
      lo_r    <= '0;
      hi_r    <= count;
      hv_ok_r <= 1'b0;
      hv_eq_r <= 1'b0;
    end else if (ctrl.step) begin
      if (go_right) begin
        lo_r <= mid + CW'(1);
      end else begin
        hi_r    <= mid;
        hv_ok_r <= 1'b1;
        hv_eq_r <= eq;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.step && !go_right) begin
      hv_r <= rd_data;
    end
  end

  assign pos     = lo_r;
  assign hit_key = hv_r;
  assign hit_ok  = hv_ok_r;
  assign hit_eq  = hv_eq_r;

endmodule

`default_nettype wire

@@ tb/sorted_key_table_find_or_insert_core_tb.sv @@
// ---------------------------------------------------------------------------
// Sorted key table find-or-insert core testbench
// Drives find-or-insert, find-only, next-greater and unused-op requests at
// the core and keeps its own copy of the sorted table to work out every
// result. Results are compared field by field in arrival order. The run
// walks through three stall patterns and several end-key values, includes
// a long output hold-off and fills the table until inserts are refused.
// ---------------------------------------------------------------------------

module sorted_key_table_find_or_insert_core_tb;
  import skt_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED     = 2'd3;
  localparam key_t            KEY_MAX       = {KEY_W{1'b1}};
  localparam int              PHASE_ITEMS   = 195;
  localparam int              HOLD_CYCLES   = 300;
  localparam int              SETTLE_CYCLES = 200;
  localparam int              MAX_REPORTS   = 50;
  localparam longint          LIMIT_TIME    = 64'd10_000_000;

  typedef struct packed {
    logic [IDX_W-1:0] index;
    logic             found;
    logic             inserted;
    logic             full_res;
    key_t             next_key;
  } lookup_result_t;

  // Sorted table copy, expected lookup results and mismatch count
  class key_table_scoreboard;
    key_t           keys[CAPACITY];
    int unsigned    n_keys;
    key_t           end_key;
    lookup_result_t expected_results[$];
    int unsigned    n_errors, n_requests, n_results;
    int unsigned    n_inserted, n_hits, n_full, n_end_key, n_unused;

    function new();
      n_keys     = 0;
      end_key    = '0;
      n_errors   = 0;
      n_requests = 0;
      n_results  = 0;
      n_inserted = 0;
      n_hits     = 0;
      n_full     = 0;
      n_end_key  = 0;
      n_unused   = 0;
    endfunction

    // First stored position holding a key >= k (> k when strict)
    function int unsigned lower_bound(key_t k, bit strict);
      int unsigned lo, hi, mid;
      lo = 0;
      hi = n_keys;
      while (lo < hi) begin
        mid = lo + (hi - lo) / 2;
        if (strict ? (keys[mid] <= k) : (keys[mid] < k)) lo = mid + 1;
        else hi = mid;
      end
      return lo;
    endfunction

    // Apply one accepted request to the table and queue its result
    function void note_request(logic [OP_W-1:0] op, key_t k);
      lookup_result_t r;
      int unsigned    p;
      r = '0;
      n_requests++;
      case (op)
        OP_FIND_INS, OP_FIND: begin
          p = lower_bound(k, 1'b0);
          if (p < n_keys && keys[p] == k) begin
            r.index = p[IDX_W-1:0];
            r.found = 1'b1;
            n_hits++;
          end else if (op == OP_FIND_INS) begin
            if (n_keys >= CAPACITY) begin
              r.full_res = 1'b1;
              n_full++;
            end else begin
              // Shift the later entries up one place, then drop the key in
              for (int unsigned i = n_keys; i > p; i--) keys[i] = keys[i-1];
              keys[p] = k;
              n_keys++;
              r.index    = p[IDX_W-1:0];
              r.inserted = 1'b1;
              n_inserted++;
            end
          end
        end
        OP_NEXT: begin
          p = lower_bound(k, 1'b1);
          if (p < n_keys) begin
            r.index    = p[IDX_W-1:0];
            r.found    = 1'b1;
            r.next_key = keys[p];
          end else begin
            r.next_key = end_key;
            n_end_key++;
          end
        end
        default: n_unused++;
      endcase
      expected_results = {expected_results, r};
    endfunction

    // Print one line per mismatch (quietly after MAX_REPORTS of them) and count
    task report(string msg);
      n_errors++;
      if (n_errors <= MAX_REPORTS) $display("mismatch at %0t: %s", $time, msg);
    endtask

    task check_result(lookup_result_t got);
      lookup_result_t want;
      if (expected_results.size() == 0) begin
        report("result transaction with no request outstanding");
        return;
      end
      want = expected_results.pop_front();
      n_results++;
      if (got.index !== want.index)
        report($sformatf("result %0d index %0d, expected %0d",
                         n_results, got.index, want.index));
      if (got.found !== want.found)
        report($sformatf("result %0d found %b, expected %b",
                         n_results, got.found, want.found));
      if (got.inserted !== want.inserted)
        report($sformatf("result %0d inserted %b, expected %b",
                         n_results, got.inserted, want.inserted));
      if (got.full_res !== want.full_res)
        report($sformatf("result %0d full_res %b, expected %b",
                         n_results, got.full_res, want.full_res));
      if (got.next_key !== want.next_key)
        report($sformatf("result %0d next_key %h, expected %h",
                         n_results, got.next_key, want.next_key));
    endtask

    function int unsigned pending();
      return expected_results.size();
    endfunction

    function key_t stored_key(int unsigned i);
      return keys[i];
    endfunction
  endclass

  logic             clk          = 1'b0;
  logic             rst_n        = 1'b0;
  logic             cfg_valid    = 1'b0;
  logic             cfg_ready;
  key_t             cfg_end_key  = '0;
  logic             in_valid     = 1'b0;
  logic             in_stall;
  logic [OP_W-1:0]  in_op        = '0;
  key_t             in_key       = '0;
  logic             out_valid;
  logic             out_stall    = 1'b0;
  logic [IDX_W-1:0] out_index;
  logic             out_found;
  logic             out_inserted;
  logic             out_full_res;
  key_t             out_next_key;

  int unsigned      tx_idle_pct  = 0;
  int unsigned      rx_idle_pct  = 0;
  bit               hold_start   = 1'b0;
  key_table_scoreboard sb;

  always #5 clk = ~clk;

  sorted_key_table_find_or_insert_core dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_end_key  (cfg_end_key),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_op        (in_op),
    .in_key       (in_key),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_index    (out_index),
    .out_found    (out_found),
    .out_inserted (out_inserted),
    .out_full_res (out_full_res),
    .out_next_key (out_next_key)
  );

  // Note accepted requests, then check accepted results, on pre-edge values
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_request(in_op, in_key);
      if (out_valid && !out_stall)
        sb.check_result({out_index, out_found, out_inserted, out_full_res, out_next_key});
    end
  end

  // Result side: random stalls, or a counted hold-off when asked for
  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_start) begin
        hold_start = 1'b0;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  // Offer one request, with random idle cycles first, and hold it until taken
  task automatic send_request(logic [OP_W-1:0] op, key_t k);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op    <= op;
    in_key   <= k;
    do @(posedge clk); while (in_stall);
  endtask

  // Stop offering and wait until every outstanding result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_end_key(key_t v);
    cfg_valid   <= 1'b1;
    cfg_end_key <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.end_key = v;
  endtask

  function automatic logic [OP_W-1:0] pick_op();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 40) return OP_FIND_INS;
    if (roll < 65) return OP_FIND;
    if (roll < 92) return OP_NEXT;
    return OP_UNUSED;
  endfunction

  // Mostly stored keys and their neighbours so lookups hit, plus extremes
  // and fresh random keys that fill the table over the run
  function automatic key_t pick_key();
    int unsigned roll;
    key_t        k;
    roll = $urandom_range(99);
    k    = key_t'($urandom);
    if (sb.n_keys != 0 && roll < 45) begin
      k = sb.stored_key($urandom_range(sb.n_keys - 1));
    end else if (sb.n_keys != 0 && roll < 62) begin
      k = sb.stored_key($urandom_range(sb.n_keys - 1));
      k = roll[0] ? k + 1'b1 : k - 1'b1;
    end else if (roll < 70) begin
      k = roll[0] ? KEY_MAX : '0;
    end
    return k;
  endfunction

  initial begin : stimulus
    sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty table with end key at its reset value
    send_request(OP_NEXT, '0);
    send_request(OP_FIND, key_t'(5));
    wait_drained();
    write_end_key(KEY_MAX);

    // Inserts at front, back and middle, then repeats and lookups
    send_request(OP_FIND_INS, key_t'(1000));
    send_request(OP_FIND_INS, '0);
    send_request(OP_FIND_INS, KEY_MAX);
    send_request(OP_FIND_INS, key_t'(500));
    send_request(OP_FIND_INS, key_t'(1000));
    send_request(OP_FIND, '0);
    send_request(OP_FIND, KEY_MAX);
    send_request(OP_FIND, key_t'(501));
    send_request(OP_NEXT, '0);
    send_request(OP_NEXT, key_t'(499));
    send_request(OP_NEXT, KEY_MAX - 1'b1);
    send_request(OP_NEXT, KEY_MAX);
    send_request(OP_UNUSED, KEY_MAX);
    send_request(OP_UNUSED, '0);
    send_request(OP_FIND_INS, key_t'(31'h5555_5555));
    send_request(OP_FIND_INS, key_t'(31'h2AAA_AAAA));

    // Three stall patterns, each with its own end key
    for (int phase = 0; phase < 3; phase++) begin
      wait_drained();
      case (phase)
        0: begin
          tx_idle_pct = 24;
          rx_idle_pct = 82;
          write_end_key(key_t'($urandom));
        end
        1: begin
          tx_idle_pct = 82;
          rx_idle_pct = 24;
          write_end_key('0);
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
          write_end_key(key_t'(31'h4000_0000));
        end
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // Pause the input until all results are back
        if (phase == 0 && i == 100) wait_drained();
        // Hold the output off while requests keep coming
        if (phase == 2 && i == 40) hold_start = 1'b1;
        send_request(pick_op(), pick_key());
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("run covered %0d requests over three stall patterns: %0d inserts, %0d hits,",
             sb.n_requests, sb.n_inserted, sb.n_hits);
    $display("%0d refused on a full table, %0d end-key answers, %0d unused ops; %0d mismatches",
             sb.n_full, sb.n_end_key, sb.n_unused, sb.n_errors);
    if (sb.n_errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Give up if the run hangs
  initial begin : watchdog
    #(LIMIT_TIME);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/skt_pkg.sv
rtl/skt_search.sv
rtl/sorted_key_table_find_or_insert_core.sv
tb/sorted_key_table_find_or_insert_core_tb.sv
